/* rtl/core/sdo_client_upload_engine_defines.svh */
// Assertion macros used by the SDO upload engine RTL.
`ifndef SDO_CLIENT_UPLOAD_ENGINE_DEFINES_SVH
`define SDO_CLIENT_UPLOAD_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDOUP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDOUP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/sdoup_pkg.sv */
// Types, constants and codes for the SDO upload engine.
package sdoup_pkg;

	// CAN identifiers and SDO command bytes
	localparam logic [10:0] TX_BASE      = 11'h600;
	localparam logic [10:0] RX_BASE      = 11'h580;
	localparam logic [7:0]  CMD_UP_INIT  = 8'h40;
	localparam logic [7:0]  CMD_UP_SEG   = 8'h60;

	localparam logic [15:0] TIMEOUT_RST  = 16'd100;
	localparam int          FIFO_DEPTH   = 4;

	// input item selector
	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_FRAME = 2'd1;
	localparam logic [1:0] FN_TICK  = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_TX    = 3'd0;
	localparam logic [2:0] KIND_VALUE = 3'd1;
	localparam logic [2:0] KIND_SEG   = 3'd2;
	localparam logic [2:0] KIND_DONE  = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;

	// error codes
	localparam logic [1:0] ERR_TIMEOUT = 2'd0;
	localparam logic [1:0] ERR_LENGTH  = 2'd1;
	localparam logic [1:0] ERR_SIZE    = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_INIT = 2'd1,
		PH_SEG  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [6:0]  node_id;
		logic [15:0] object_index;
		logic [7:0]  object_subindex;
		logic [2:0]  value_size;
		logic        signed_value;
		logic        segmented;
		logic [10:0] frame_id;
		logic [63:0] frame_data;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [6:0]  node;
		logic [15:0] index;
		logic [7:0]  subindex;
		logic [3:0]  size_sign;
		logic        seg_mode;
		logic        toggle;
		logic [31:0] exp_len;
		logic [31:0] rcv_len;
		logic [15:0] wait_cnt;
	} state_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [10:0]        tx_id;
		logic [63:0]        tx_data;
		logic signed [32:0] number_value;
		logic [55:0]        segment_bytes;
		logic [2:0]         segment_count;
		logic [1:0]         error_code;
		logic               last;
	} result_t;

endpackage

/* rtl/core/sdoup_step.sv */
// Protocol step: decodes one item against the transfer state, gives next state and results.
module sdoup_step import sdoup_pkg::*; (
	input  logic [15:0] timeout_ticks,
	input  state_t      cur,
	input  item_t       item,
	output state_t      nxt,
	output result_t     res0,
	output result_t     res1,
	output logic [1:0]  nres
);

	logic [63:0] d;
	logic [6:0]  node_sel;
	logic [10:0] tx_id;
	logic        rx_match;
	logic        init_match;
	logic        seg_match;
	logic [2:0]  seg_cnt;
	logic [55:0] seg_bytes;
	logic [32:0] len_sum;
	logic [31:0] len_sat;
	logic [15:0] wait_inc;
	logic        sg;

	assign d          = item.frame_data;
	assign node_sel   = (item.func == FN_START) ? item.node_id : cur.node;
	assign tx_id      = TX_BASE + {4'b0, node_sel};
	assign rx_match   = (item.frame_id == (RX_BASE + {4'b0, cur.node}));
	assign init_match = (cur.phase == PH_INIT) && rx_match &&
		(d[23:8] == cur.index) && (d[31:24] == cur.subindex);
	assign seg_match  = (cur.phase == PH_SEG) && rx_match && (d[4] == cur.toggle);
	assign sg         = cur.size_sign[3];

	// segment payload: 7 - n bytes valid
	assign seg_cnt = 3'd7 - d[3:1];
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			seg_bytes[8*i +: 8] = (3'(i) < seg_cnt) ? d[8*i+8 +: 8] : 8'h00;
		end
	end

	// saturating running length
	assign len_sum  = {1'b0, cur.rcv_len} + {30'b0, seg_cnt};
	assign len_sat  = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
	assign wait_inc = (cur.wait_cnt != 16'hFFFF) ? cur.wait_cnt + 16'd1 : cur.wait_cnt;

	// next state and results
	always_comb begin
		nxt  = cur;
		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		case (item.func)
			FN_START: begin
				nxt.node      = item.node_id;
				nxt.index     = item.object_index;
				nxt.subindex  = item.object_subindex;
				nxt.size_sign = {item.signed_value, item.value_size};
				nxt.seg_mode  = item.segmented;
				nxt.toggle    = 1'b0;
				nxt.exp_len   = '0;
				nxt.rcv_len   = '0;
				nxt.wait_cnt  = '0;
				nxt.phase     = PH_INIT;
				res0.kind     = KIND_TX;
				res0.tx_id    = tx_id;
				res0.tx_data  = {32'b0, item.object_subindex, item.object_index, CMD_UP_INIT};
				nres          = 2'd1;
			end
			FN_FRAME: begin
				if (init_match) begin
					nxt.wait_cnt = '0;
					nres         = 2'd1;
					if (cur.seg_mode) begin
						nxt.exp_len  = d[63:32];
						nxt.rcv_len  = '0;
						nxt.toggle   = 1'b0;
						nxt.phase    = PH_SEG;
						res0.kind    = KIND_TX;
						res0.tx_id   = tx_id;
						res0.tx_data = {56'b0, CMD_UP_SEG};
					end else begin
						nxt.phase = PH_IDLE;
						res0.kind = KIND_VALUE;
						case (cur.size_sign[2:0])
							3'd1: res0.number_value = {{25{sg & d[39]}}, d[39:32]};
							3'd2: res0.number_value = {{17{sg & d[47]}}, d[47:32]};
							3'd4: res0.number_value = {sg & d[63], d[63:32]};
							default: begin
								res0.kind       = KIND_ERR;
								res0.error_code = ERR_SIZE;
							end
						endcase
					end
				end else if (seg_match) begin
					nxt.wait_cnt       = '0;
					nxt.rcv_len        = len_sat;
					res0.kind          = KIND_SEG;
					res0.segment_bytes = seg_bytes;
					res0.segment_count = seg_cnt;
					nres               = 2'd2;
					if (d[0]) begin
						nxt.phase = PH_IDLE;
						if (len_sat == cur.exp_len) begin
							res1.kind = KIND_DONE;
						end else begin
							res1.kind       = KIND_ERR;
							res1.error_code = ERR_LENGTH;
						end
					end else begin
						nxt.toggle   = ~cur.toggle;
						res1.kind    = KIND_TX;
						res1.tx_id   = tx_id;
						res1.tx_data = {56'b0, CMD_UP_SEG | {3'b0, ~cur.toggle, 4'b0}};
					end
				end
			end
			FN_TICK: begin
				if (cur.phase != PH_IDLE) begin
					if (wait_inc >= timeout_ticks) begin
						nxt.phase       = PH_IDLE;
						nxt.wait_cnt    = '0;
						res0.kind       = KIND_ERR;
						res0.error_code = ERR_TIMEOUT;
						nres            = 2'd1;
					end else begin
						nxt.wait_cnt = wait_inc;
					end
				end
			end
			default: begin
			end
		endcase
		// mark the final result of this item
		if (nres == 2'd1) res0.last = 1'b1;
		if (nres == 2'd2) res1.last = 1'b1;
	end

endmodule

/* rtl/core/sdoup_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one.
module sdoup_fifo import sdoup_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_n,
	input  result_t                    din0,
	input  result_t                    din1,
	input  logic                       pop,
	output result_t                    dout,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic [PW-1:0]   wp1;
	logic [PW-1:0]   wp2;
	logic [PW-1:0]   rp1;
	logic            do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1    = ptr_inc(wp_q);
	assign wp2    = ptr_inc(wp1);
	assign rp1    = ptr_inc(rp_q);
	assign do_pop = pop && (cnt_q != '0);
	assign dout   = mem_q[rp_q];
	assign count  = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wp_q] <= din0;
		if (push_n == 2'd2) mem_q[wp1]  <= din1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) wp_q <= wp1;
			else if (push_n == 2'd2) wp_q <= wp2;
			if (do_pop) rp_q <= rp1;
			cnt_q <= cnt_q + CW'(push_n) - CW'(do_pop);
		end
	end

endmodule

/* rtl/core/sdo_client_upload_engine.sv */
// SDO client upload engine: one input register, one step of decode, a small result queue.
// Flow: an accepted item is registered in stage 1 and decoded in the next cycle; its results
// are written into the queue when stage 1 moves on and are offered on the master side in order.
// Throughput: one item per cycle while results drain as fast; the queue (DEPTH entries)
// stalls input when fewer than two free entries remain. Items with two results take two entries.
// Reset: arst_n clears the transfer state to idle, empties the queue, timeout to 100.
`include "sdo_client_upload_engine_defines.svh"

module sdo_client_upload_engine import sdoup_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// item input
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// node_id[6:0], object_index[22:7], object_subindex[30:23], value_size[33:31],
	// signed_value[34], segmented[35], frame_id[46:36], frame_data[110:47], zero[111]
	input  logic [111:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]   s_axis_tuser,
	// result output
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tx_id[10:0], tx_data[74:11], number_value[107:75], segment_bytes[163:108],
	// segment_count[166:164], error_code[168:167], zero[175:169]
	output logic [175:0] m_axis_tdata,
	// result_kind[2:0]
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int CW = $clog2(DEPTH+1);

	logic [15:0]   timeout_q;
	item_t         item_in;
	item_t         item_s1;
	logic          vld_s1;
	logic          adv;
	state_t        st_q;
	state_t        st_nxt;
	result_t       res0;
	result_t       res1;
	logic [1:0]    nres;
	result_t       head;
	logic [CW-1:0] fifo_cnt;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'b0, timeout_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// unpack the input transaction
	assign item_in = '{
		func:            s_axis_tuser,
		node_id:         s_axis_tdata[6:0],
		object_index:    s_axis_tdata[22:7],
		object_subindex: s_axis_tdata[30:23],
		value_size:      s_axis_tdata[33:31],
		signed_value:    s_axis_tdata[34],
		segmented:       s_axis_tdata[35],
		frame_id:        s_axis_tdata[46:36],
		frame_data:      s_axis_tdata[110:47]
	};

	// stage 1 moves on when the queue has room for two results
	assign adv           = vld_s1 && (fifo_cnt <= CW'(DEPTH-2));
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) item_s1 <= item_in;
	end

	// transfer state
	sdoup_step u_step (
		.timeout_ticks (timeout_q),
		.cur           (st_q),
		.item          (item_s1),
		.nxt           (st_nxt),
		.res0          (res0),
		.res1          (res1),
		.nres          (nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result queue
	sdoup_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (adv ? nres : 2'd0),
		.din0   (res0),
		.din1   (res1),
		.pop    (m_axis_tready),
		.dout   (head),
		.count  (fifo_cnt)
	);

	// pack the output transaction
	assign m_axis_tvalid = (fifo_cnt != '0);
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {7'b0, head.error_code, head.segment_count, head.segment_bytes,
		head.number_value, head.tx_data, head.tx_id};

	// checks
	`SDOUP_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, fifo_cnt <= CW'(DEPTH),
		"result queue over its depth")
	`SDOUP_ASSERT_IMP(a_pair_held, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		fifo_cnt >= CW'(2), "first of a result pair without its partner queued")
	`SDOUP_ASSERT_IMP(a_no_stall, clk, arst_n, fifo_cnt <= CW'(DEPTH-2), s_axis_tready,
		"input stalled with room in the result queue")
	`SDOUP_ASSERT_NXT(a_start_phase, clk, arst_n, adv && (item_s1.func == FN_START),
		st_q.phase == PH_INIT, "start did not enter the initiate phase")

endmodule
